>>> hdl/wrpnr_pkg.sv
// shared constants, widths, codes and types of the weighted random picker
// no dependencies; imported by every module of the block
package wrpnr_pkg;

  // sizes of the block
  localparam int MAX_ENTRIES   = 16;
  localparam int HISTORY_DEPTH = 8;
  localparam int WEIGHT_BITS   = 16;
  localparam int RANDOM_BITS   = 16;

  // fixed port widths
  localparam int OPCODE_W = 2;
  localparam int IN_W     = 16;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 4;
  localparam int RCNT_W   = 4;

  // derived widths
  localparam int ENTRY_IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W    = WEIGHT_BITS + $clog2(MAX_ENTRIES);
  localparam int HIST_IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HCNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int PROD_W   = IN_W + SUM_W;
  localparam int MASK_IW  = $clog2(IN_W);

  localparam logic [IN_W-1:0] WEIGHT_IN_MASK = IN_W'((64'd1 << WEIGHT_BITS) - 64'd1);
  localparam logic [IN_W-1:0] RANDOM_IN_MASK = IN_W'((64'd1 << RANDOM_BITS) - 64'd1);

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PICKED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJ_SKIP   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJ_REPEAT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NO_REPEAT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_LEVEL = 1'd1;

  // history commands from the sequencer
  typedef struct packed {
    logic clear;
    logic push;
  } hist_ctrl_t;

endpackage

>>> hdl/wrpnr_wtab.sv
// weight table memory: one write port, one registered read port
// depends on wrpnr_pkg
module wrpnr_wtab (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [wrpnr_pkg::ENTRY_IW-1:0]      wr_addr,
  input  logic [wrpnr_pkg::WEIGHT_BITS-1:0]   wr_data,
  input  logic [wrpnr_pkg::ENTRY_IW-1:0]      rd_addr,
  output logic [wrpnr_pkg::WEIGHT_BITS-1:0]   rd_data
);
  import wrpnr_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/wrpnr_hist.sv
// recent-pick history: ordered list, oldest at slot 0, with drop and push
// depends on wrpnr_pkg
module wrpnr_hist (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wrpnr_pkg::hist_ctrl_t            ctrl,
  input  logic [wrpnr_pkg::ENTRY_IW-1:0]   push_idx,
  input  logic [wrpnr_pkg::RCNT_W-1:0]     drop_level,
  input  logic [wrpnr_pkg::HIST_IW-1:0]    rd_addr,
  output logic [wrpnr_pkg::ENTRY_IW-1:0]   rd_data,
  output logic [wrpnr_pkg::HCNT_W-1:0]     count
);
  import wrpnr_pkg::*;

  logic [ENTRY_IW-1:0] hist_r [HISTORY_DEPTH];
  logic [HCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                drop_rc, drop_full, drop;
  logic [HCNT_W-1:0]   cnt_after_drop;
  logic [HIST_IW-1:0]  slot;

  // oldest entry goes when the count reached drop_level, or when full
  always_comb begin
    drop_rc        = (cnt_r != '0) && (32'(cnt_r) >= 32'(drop_level));
    drop_full      = (32'(cnt_r) >= HISTORY_DEPTH);
    drop           = drop_rc || drop_full;
    cnt_after_drop = drop ? (cnt_r - HCNT_W'(1)) : cnt_r;
    slot           = HIST_IW'(cnt_after_drop);
    cnt_nxt        = cnt_r;
    if (ctrl.clear) begin
      cnt_nxt = '0;
    end else if (ctrl.push) begin
      cnt_nxt = cnt_after_drop + HCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // each slot takes either the new pick or its upper neighbor
  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      for (int j = 0; j < HISTORY_DEPTH - 1; j++) begin
        if (HIST_IW'(j) == slot) begin
          hist_r[j] <= push_idx;
        end else if (drop) begin
          hist_r[j] <= hist_r[j+1];
        end
      end
      if (slot == HIST_IW'(HISTORY_DEPTH - 1)) begin
        hist_r[HISTORY_DEPTH-1] <= push_idx;
      end
    end
  end

  assign rd_data = hist_r[rd_addr];
  assign count   = cnt_r;

endmodule

>>> hdl/weighted_random_pick_no_repeat.sv
// top level of the weighted random picker: sequencer, target multiply, prefix walk
// depends on wrpnr_pkg, wrpnr_wtab and wrpnr_hist
//
// Weighted lottery picker. Clear and append words keep busy low, and the result word
// shows on the next cycle. A select word raises busy, registers the target, walks the
// prefix sums up to the picked entry and, when the avoid-repeat register is set,
// searches the recent-pick history. The select time is set by the prefix walk, which
// adds one weight per cycle from the single read port of the weight memory, and by the
// history search, which checks one slot per cycle with one comparator. Every word
// gives exactly one result word, out_strobe high for one cycle; the receiver cannot
// stall, so it must take the result in that cycle. The user must write configuration
// through cfg_we / cfg_index / cfg_wdata only while busy is low and no result is
// pending; the block itself does not enforce this.
module weighted_random_pick_no_repeat (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [wrpnr_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [wrpnr_pkg::IN_W-1:0]          in_weight,
  input  logic [wrpnr_pkg::IN_W-1:0]          in_random_fraction,
  input  logic [wrpnr_pkg::IN_W-1:0]          in_skip_mask,
  output logic                                out_strobe,
  output logic [wrpnr_pkg::STATUS_W-1:0]      out_status,
  output logic [wrpnr_pkg::INDEX_W-1:0]       out_picked_index,
  input  logic                                cfg_we,
  input  logic [wrpnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wrpnr_pkg::CFG_W-1:0]         cfg_wdata
);
  import wrpnr_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_SRCH = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic                  avoid_r;
  logic [RCNT_W-1:0]     repcnt_r;
  logic [CNT_W-1:0]      entry_cnt_r, entry_cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [IN_W-1:0]       rand_r, rand_nxt;
  logic [IN_W-1:0]       mask_r, mask_nxt;
  logic [SUM_W-1:0]      target_r, target_nxt;
  logic [SUM_W-1:0]      prefix_r, prefix_nxt;
  logic [ENTRY_IW-1:0]   idx_r, idx_nxt;
  logic [HCNT_W-1:0]     k_r, k_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]    out_index_r, out_index_nxt;

  logic                  accept;
  logic                  wt_we;
  logic [WEIGHT_BITS-1:0] wt_wdata;
  logic [WEIGHT_BITS-1:0] wt_rdata;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      prefix_sum;
  logic                  hit, last_entry, skip_hit;
  hist_ctrl_t            hctrl;
  logic [ENTRY_IW-1:0]   hist_rdata;
  logic [HCNT_W-1:0]     hist_cnt;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // appended weight, cut to the table width
  assign wt_wdata = WEIGHT_BITS'(in_weight & WEIGHT_IN_MASK);

  // target = (random * sum) >> RANDOM_BITS, registered before the walk
  assign prod = PROD_W'(rand_r) * PROD_W'(sum_r);

  // shared add and compare of the prefix walk
  assign prefix_sum = prefix_r + SUM_W'(wt_rdata);
  assign hit        = (prefix_sum >= target_r);
  assign last_entry = ((CNT_W'(idx_r) + CNT_W'(1)) == entry_cnt_r);
  // entries beyond the mask width cannot be skipped
  assign skip_hit   = (32'(idx_r) < IN_W) && mask_r[MASK_IW'(idx_r)];

  wrpnr_wtab u_wtab (
    .clk     (clk),
    .wr_en   (wt_we),
    .wr_addr (entry_cnt_r[ENTRY_IW-1:0]),
    .wr_data (wt_wdata),
    .rd_addr (idx_nxt),
    .rd_data (wt_rdata)
  );

  wrpnr_hist u_hist (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (hctrl),
    .push_idx     (idx_r),
    .drop_level   (repcnt_r),
    .rd_addr      (HIST_IW'(k_r)),
    .rd_data      (hist_rdata),
    .count        (hist_cnt)
  );

  always_comb begin
    state_nxt      = state_r;
    entry_cnt_nxt  = entry_cnt_r;
    sum_nxt        = sum_r;
    rand_nxt       = rand_r;
    mask_nxt       = mask_r;
    target_nxt     = target_r;
    prefix_nxt     = prefix_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    wt_we          = 1'b0;
    hctrl          = '0;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          case (in_opcode)
            OP_CLEAR: begin
              entry_cnt_nxt  = '0;
              sum_nxt        = '0;
              hctrl.clear    = 1'b1;
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_DONE;
              out_index_nxt  = '0;
            end
            OP_APPEND: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_DONE;
              out_index_nxt  = '0;
              // a full table ignores the append
              if (32'(entry_cnt_r) < MAX_ENTRIES) begin
                wt_we         = 1'b1;
                sum_nxt       = sum_r + SUM_W'(wt_wdata);
                entry_cnt_nxt = entry_cnt_r + CNT_W'(1);
                out_index_nxt = INDEX_W'(entry_cnt_r);
              end
            end
            OP_SELECT: begin
              rand_nxt  = in_random_fraction & RANDOM_IN_MASK;
              mask_nxt  = in_skip_mask;
              state_nxt = S_MUL;
            end
            default: begin
              out_strobe_nxt = 1'b1;
              out_status_nxt = ST_DONE;
              out_index_nxt  = '0;
            end
          endcase
        end
      end
      S_MUL: begin
        target_nxt = SUM_W'(prod >> RANDOM_BITS);
        prefix_nxt = '0;
        idx_nxt    = '0;
        if (entry_cnt_r == '0) begin
          // empty table: nothing to pick, history forgotten
          hctrl.clear    = 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_NONE;
          out_index_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        prefix_nxt = prefix_sum;
        if (hit) begin
          out_index_nxt = INDEX_W'(idx_r);
          if (skip_hit) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_REJ_SKIP;
            state_nxt      = S_IDLE;
          end else if (!avoid_r) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = ST_PICKED;
            state_nxt      = S_IDLE;
          end else begin
            k_nxt     = '0;
            state_nxt = S_SRCH;
          end
        end else if (last_entry) begin
          // target beyond the running sum of all entries
          hctrl.clear    = 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_NONE;
          out_index_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + ENTRY_IW'(1);
        end
      end
      S_SRCH: begin
        // one history slot per cycle, oldest first
        if (k_r >= hist_cnt) begin
          hctrl.push     = 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_PICKED;
          state_nxt      = S_IDLE;
        end else if (hist_rdata == idx_r) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_REJ_REPEAT;
          state_nxt      = S_IDLE;
        end else begin
          k_nxt = k_r + HCNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      entry_cnt_r  <= '0;
      sum_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      entry_cnt_r  <= entry_cnt_nxt;
      sum_r        <= sum_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avoid_r  <= 1'b0;
      repcnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NO_REPEAT:  avoid_r  <= cfg_wdata[0];
        REG_DROP_LEVEL: repcnt_r <= RCNT_W'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    rand_r       <= rand_nxt;
    mask_r       <= mask_nxt;
    target_r     <= target_nxt;
    prefix_r     <= prefix_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_picked_index = out_index_r;

endmodule

>>> hdl/wrpnr_checker.sv
// port-level checks of the weighted random picker, bound to the top level
// depends on wrpnr_pkg and weighted_random_pick_no_repeat
module wrpnr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_strobe,
  input logic [wrpnr_pkg::STATUS_W-1:0]      out_status,
  input logic [wrpnr_pkg::INDEX_W-1:0]       out_picked_index
);
  import wrpnr_pkg::*;

  // an accepted word either answers at once or keeps the block busy
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe || busy)
    else $error("accepted word neither answered nor held busy");

  // a select ends only with a result word
  a_busy_ends_with_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result word");

  // a result word never appears while a select is still running
  a_word_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  // status codes and the index of an empty pick
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_PICKED || out_status == ST_REJ_SKIP ||
                    out_status == ST_REJ_REPEAT || out_status == ST_NONE ||
                    out_status == ST_DONE))
    else $error("illegal status code");

  a_none_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ST_NONE |-> out_picked_index == '0)
    else $error("empty pick with nonzero index");

endmodule

bind weighted_random_pick_no_repeat wrpnr_checker u_wrpnr_checker (.*);
